/* design/mhpq_pkg.sv */
// shared types and constants for the min-heap priority queue
// no dependencies; imported by min_heap_priority_queue
package mhpq_pkg;

    localparam int HEAP_DEPTH = 16;
    localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    // child index width, holds 2*pos+2 for any pos below the depth
    localparam int CHD_W      = IDX_W + 2;
    localparam int KEY_W      = 32;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int ECNT_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_RD,
        ST_POP_LD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_PUT,
        ST_DONE
    } t_state;

endpackage

/* design/min_heap_priority_queue.sv */
// min-heap priority queue: push, pop minimum, peek, one result per transaction
// depends on mhpq_pkg
//
// An item is taken only while the block is idle, and each item returns one result
// with a status, the minimum after the operation and the entry count. All keys sit
// in one heap memory with two read ports and one write port, read data registered.
// The key being sifted rides in a register and only the entries it passes are
// written back, so every heap level takes a read state and then a compare and
// write state. Peek, error and single-entry pop items go straight to the done
// state; a push into an empty queue writes its key in the put state, any other
// push climbs through read and compare states per level and ends in the put
// state when it reaches the root; a pop reads the last entry, loads it as the
// key and descends through read and compare states per level, ending in the put
// state when no child is left. Sift length is bounded by log2 of HEAP_DEPTH. A
// finished result waits in an output register, and the next item can be taken
// meanwhile; while that register still holds a result nobody has taken, the
// next finished item waits and the input stays stalled.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [KEY_W-1:0]  i_key_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [KEY_W-1:0]  o_min_value,
    output logic [ECNT_W-1:0]        o_entry_count
);

    logic signed [KEY_W-1:0] heap_mem [HEAP_DEPTH];

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    t_status                 r_status, n_status;
    logic signed [KEY_W-1:0] r_root;
    logic signed [KEY_W-1:0] r_rd_a, r_rd_b;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic signed [KEY_W-1:0] r_out_min;
    logic [ECNT_W-1:0]       r_out_cnt;

    logic                    in_acc;
    logic                    out_load;
    logic                    mem_we;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic [IDX_W-1:0]        rd_addr_a, rd_addr_b;

    logic [IDX_W-1:0]        up_idx;
    logic [CHD_W-1:0]        left_idx, right_idx;
    logic                    left_ok, right_ok;
    logic                    pick_right;
    logic [IDX_W-1:0]        pick_idx;
    logic signed [KEY_W-1:0] pick_val;
    logic                    up_less, dn_less;
    logic [31:0]             cnt_ext;

    assign o_ready   = (r_state == ST_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // heap index arithmetic around the current hole
    assign up_idx    = IDX_W'((r_pos - 1'b1) >> 1);
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign left_ok   = left_idx < CHD_W'(r_count);
    assign right_ok  = right_idx < CHD_W'(r_count);

    assign pick_right = right_ok && (r_rd_b < r_rd_a);
    assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
    assign pick_val   = pick_right ? r_rd_b : r_rd_a;
    assign up_less    = r_key < r_rd_a;
    assign dn_less    = pick_val < r_key;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_operation))
                        OP_PUSH: begin
                            if (r_count == CNT_W'(HEAP_DEPTH)) begin
                                n_state = ST_DONE;
                            end else if (r_count == '0) begin
                                n_state = ST_PUT;
                            end else begin
                                n_state = ST_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_count > CNT_W'(1)) begin
                                n_state = ST_POP_RD;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_UP_RD:  n_state = ST_UP_CMP;
            ST_UP_CMP: begin
                if (!up_less) begin
                    n_state = ST_DONE;
                end else if (up_idx == '0) begin
                    n_state = ST_PUT;
                end else begin
                    n_state = ST_UP_RD;
                end
            end
            ST_POP_RD: n_state = ST_POP_LD;
            ST_POP_LD: n_state = ST_DN_RD;
            ST_DN_RD:  n_state = left_ok ? ST_DN_CMP : ST_PUT;
            ST_DN_CMP: n_state = dn_less ? ST_DN_RD : ST_DONE;
            ST_PUT:    n_state = ST_DONE;
            ST_DONE:   n_state = out_load ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_status  = r_status;
        mem_we    = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_key;
        rd_addr_a = r_pos;
        rd_addr_b = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_status = STAT_OK;
                    case (t_op'(i_operation))
                        OP_PUSH: begin
                            if (r_count == CNT_W'(HEAP_DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_key   = i_key_value;
                                n_pos   = r_count[IDX_W-1:0];
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            ST_UP_RD: rd_addr_a = up_idx;
            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (up_less) begin
                    wr_data = r_rd_a;
                    n_pos   = up_idx;
                end
            end
            // last entry moves to the root
            ST_POP_RD: rd_addr_a = r_count[IDX_W-1:0];
            ST_POP_LD: begin
                n_key = r_rd_a;
                n_pos = '0;
            end
            ST_DN_RD: begin
                rd_addr_a = left_idx[IDX_W-1:0];
                rd_addr_b = right_idx[IDX_W-1:0];
            end
            ST_DN_CMP: begin
                mem_we = 1'b1;
                if (dn_less) begin
                    wr_data = pick_val;
                    n_pos   = pick_idx;
                end
            end
            ST_PUT:  mem_we = 1'b1;
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            heap_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= heap_mem[rd_addr_a];
        r_rd_b <= heap_mem[rd_addr_b];
    end

    // root copy keeps the minimum at hand without a memory read
    always_ff @(posedge i_clk) begin
        if (mem_we && wr_addr == '0) begin
            r_root <= wr_data;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_min    <= (r_count != '0) ? r_root : '0;
            r_out_cnt    <= cnt_ext[ECNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_min_value   = r_out_min;
    assign o_entry_count = r_out_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CNT_W'(wr_addr) < r_count))
        else $error("heap write outside the occupied entries");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != ST_IDLE && r_state != ST_DONE))
        else $error("heap write outside a sift");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("transaction accepted without work");

    a_empty_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_min_value == '0 && o_entry_count == '0))
        else $error("empty status with nonzero minimum or count");

endmodule
